// ===== src/swq_pkg.sv =====
// shared types and constants of the sorted alarm wake-up queue
// no dependencies; used by sorted_alarm_wakeup_queue

package swq_pkg;

  // width of a wake time or a current time
  localparam int TIME_W = 63;

  // most woken items a single tick may produce
  localparam int MAX_RESULTS = 16;

  typedef enum logic [1:0] {
    FUNC_SET    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_TICK   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_SET_OK    = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_WOKEN     = 3'd4,
    ST_NONE_DUE  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SET_EV,
    S_SET_INS,
    S_RM_EV,
    S_RM_SH,
    S_TK_EV,
    S_TK_EMIT,
    S_TK_SH,
    S_RESP
  } state_t;

endpackage

// ===== src/swq_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module swq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds while no read is issued
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/sorted_alarm_wakeup_queue.sv =====
// sorted alarm wake-up queue, top level
// depends on swq_pkg and swq_ram
// channel | handshake            | payload
// --------+----------------------+--------------------------------------
// in      | in_valid / in_ready  | func, client_id, wake_time, now_time
// out     | out_valid / out_ready| status, woken_id, last
//
// set walks back over the entries at or after its slot, remove scans the
//   queue for the id and closes the gap, tick reads the due entries, emits
//   them and moves the rest down; a step does at most one read and one write of the alarm ram
// the alarm ram holds {wake time, id} sorted by time; entries at or above the
//   alarm count are never read, so the ram needs no clearing after reset
// reset clears the count, the state machine and the output valid flag only
// a result waits in the output register while the next item is accepted;
//   a stalled output holds the tick emission in place

module sorted_alarm_wakeup_queue #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                func,
  input  logic [ID_BITS-1:0]        client_id,
  input  logic [swq_pkg::TIME_W-1:0] wake_time,
  input  logic [swq_pkg::TIME_W-1:0] now_time,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic [ID_BITS-1:0]        woken_id,
  output logic                      last
);

  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EW    = swq_pkg::TIME_W + ID_BITS;
  // a tick wakes no more than this many entries
  localparam int LIM   = DEPTH < swq_pkg::MAX_RESULTS ? DEPTH : swq_pkg::MAX_RESULTS;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   LIM_X   = (CNT_W + 1)'(LIM);

  swq_pkg::state_t  state, state_next;
  swq_pkg::status_t resp, resp_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;     // entry whose data sits on rd_data
  logic [CNT_W-1:0] k, k_next;         // number of due entries of a tick
  logic [ID_BITS-1:0]        op_id, op_id_next;
  logic [swq_pkg::TIME_W-1:0] key_time, key_next;

  // ram port
  logic             rd_en, wr_en;
  logic [CNT_W-1:0] rd_idx, wr_idx;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [EW-1:0]    wr_data, rd_data;
  logic [swq_pkg::TIME_W-1:0] rd_time;
  logic [ID_BITS-1:0]         rd_id;

  // output register
  logic                out_load, out_free;
  swq_pkg::status_t    load_status, out_status;
  logic [ID_BITS-1:0]  load_id;
  logic                load_last;

  logic [CNT_W:0] idx_inc, k_inc, count_x;

  assign rd_addr = rd_idx[AW-1:0];
  assign wr_addr = wr_idx[AW-1:0];
  assign rd_time = rd_data[EW-1:ID_BITS];
  assign rd_id   = rd_data[ID_BITS-1:0];

  assign idx_inc = {1'b0, idx} + (CNT_W + 1)'(1);
  assign k_inc   = {1'b0, k} + (CNT_W + 1)'(1);
  assign count_x = {1'b0, count};

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == swq_pkg::S_IDLE);

  swq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_alarm_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= swq_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    k        <= k_next;
    resp     <= resp_next;
    op_id    <= op_id_next;
    key_time <= key_next;
    if (out_load) begin
      out_status <= load_status;
      woken_id   <= load_id;
      last       <= load_last;
    end
  end

  assign status = out_status;

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    k_next      = k;
    resp_next   = resp;
    op_id_next  = op_id;
    key_next    = key_time;
    rd_en       = 1'b0;
    rd_idx      = '0;
    wr_en       = 1'b0;
    wr_idx      = '0;
    wr_data     = rd_data;
    out_load    = 1'b0;
    load_status = resp;
    load_id     = op_id;
    load_last   = 1'b1;

    unique case (state)
      swq_pkg::S_IDLE: begin
        if (in_valid) begin
          op_id_next = client_id;
          key_next   = (func == swq_pkg::FUNC_TICK) ? now_time : wake_time;
          unique case (func)
            swq_pkg::FUNC_SET: begin
              if (count == DEPTH_C) begin
                resp_next  = swq_pkg::ST_FULL;
                state_next = swq_pkg::S_RESP;
              end else if (count == '0) begin
                idx_next   = '0;
                state_next = swq_pkg::S_SET_INS;
              end else begin
                // walk backwards from the tail, shifting later entries up
                rd_en      = 1'b1;
                rd_idx     = count - CNT_W'(1);
                idx_next   = count - CNT_W'(1);
                state_next = swq_pkg::S_SET_EV;
              end
            end
            swq_pkg::FUNC_REMOVE: begin
              if (count == '0) begin
                resp_next  = swq_pkg::ST_NOT_FOUND;
                state_next = swq_pkg::S_RESP;
              end else begin
                rd_en      = 1'b1;
                rd_idx     = '0;
                idx_next   = '0;
                state_next = swq_pkg::S_RM_EV;
              end
            end
            swq_pkg::FUNC_TICK: begin
              if (count == '0) begin
                resp_next  = swq_pkg::ST_NONE_DUE;
                state_next = swq_pkg::S_RESP;
              end else begin
                rd_en      = 1'b1;
                rd_idx     = '0;
                k_next     = '0;
                state_next = swq_pkg::S_TK_EV;
              end
            end
            default: begin
              // unused code: item taken, nothing happens
            end
          endcase
        end
      end

      swq_pkg::S_SET_EV: begin
        // equal times move up too, so the new alarm goes ahead of them
        if (rd_time >= key_time) begin
          wr_en  = 1'b1;
          wr_idx = idx_inc[CNT_W-1:0];
          if (idx == '0) begin
            state_next = swq_pkg::S_SET_INS;
          end else begin
            rd_en    = 1'b1;
            rd_idx   = idx - CNT_W'(1);
            idx_next = idx - CNT_W'(1);
          end
        end else begin
          idx_next   = idx_inc[CNT_W-1:0];
          state_next = swq_pkg::S_SET_INS;
        end
      end

      swq_pkg::S_SET_INS: begin
        wr_en      = 1'b1;
        wr_idx     = idx;
        wr_data    = {key_time, op_id};
        count_next = count + CNT_W'(1);
        resp_next  = swq_pkg::ST_SET_OK;
        state_next = swq_pkg::S_RESP;
      end

      swq_pkg::S_RM_EV: begin
        if (rd_id == op_id) begin
          resp_next = swq_pkg::ST_REMOVED;
          if (idx_inc < count_x) begin
            rd_en      = 1'b1;
            rd_idx     = idx_inc[CNT_W-1:0];
            idx_next   = idx_inc[CNT_W-1:0];
            state_next = swq_pkg::S_RM_SH;
          end else begin
            count_next = count - CNT_W'(1);
            state_next = swq_pkg::S_RESP;
          end
        end else if (idx_inc < count_x) begin
          rd_en    = 1'b1;
          rd_idx   = idx_inc[CNT_W-1:0];
          idx_next = idx_inc[CNT_W-1:0];
        end else begin
          resp_next  = swq_pkg::ST_NOT_FOUND;
          state_next = swq_pkg::S_RESP;
        end
      end

      swq_pkg::S_RM_SH: begin
        // close the gap: entry idx moves down one place
        wr_en  = 1'b1;
        wr_idx = idx - CNT_W'(1);
        if (idx_inc < count_x) begin
          rd_en    = 1'b1;
          rd_idx   = idx_inc[CNT_W-1:0];
          idx_next = idx_inc[CNT_W-1:0];
        end else begin
          count_next = count - CNT_W'(1);
          state_next = swq_pkg::S_RESP;
        end
      end

      swq_pkg::S_TK_EV: begin
        // rd_data holds entry k
        if (rd_time <= key_time) begin
          k_next = k_inc[CNT_W-1:0];
          if (k_inc < count_x && k_inc < LIM_X) begin
            rd_en  = 1'b1;
            rd_idx = k_inc[CNT_W-1:0];
          end else begin
            rd_en      = 1'b1;
            rd_idx     = '0;
            idx_next   = '0;
            state_next = swq_pkg::S_TK_EMIT;
          end
        end else if (k == '0) begin
          resp_next  = swq_pkg::ST_NONE_DUE;
          state_next = swq_pkg::S_RESP;
        end else begin
          rd_en      = 1'b1;
          rd_idx     = '0;
          idx_next   = '0;
          state_next = swq_pkg::S_TK_EMIT;
        end
      end

      swq_pkg::S_TK_EMIT: begin
        // hold the read data until the output register frees up
        if (out_free) begin
          out_load    = 1'b1;
          load_status = swq_pkg::ST_WOKEN;
          load_id     = rd_id;
          load_last   = (idx_inc == {1'b0, k});
          if (idx_inc < {1'b0, k}) begin
            rd_en    = 1'b1;
            rd_idx   = idx_inc[CNT_W-1:0];
            idx_next = idx_inc[CNT_W-1:0];
          end else if (k < count) begin
            rd_en      = 1'b1;
            rd_idx     = k;
            idx_next   = k;
            state_next = swq_pkg::S_TK_SH;
          end else begin
            count_next = count - k;
            state_next = swq_pkg::S_IDLE;
          end
        end
      end

      swq_pkg::S_TK_SH: begin
        // survivors move down past the woken entries
        wr_en  = 1'b1;
        wr_idx = idx - k;
        if (idx_inc < count_x) begin
          rd_en    = 1'b1;
          rd_idx   = idx_inc[CNT_W-1:0];
          idx_next = idx_inc[CNT_W-1:0];
        end else begin
          count_next = count - k;
          state_next = swq_pkg::S_IDLE;
        end
      end

      swq_pkg::S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_id    = (resp == swq_pkg::ST_NONE_DUE) ? '0 : op_id;
          state_next = swq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = swq_pkg::S_IDLE;
      end
    endcase
  end

  // the queue never holds more than DEPTH alarms
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("alarm count above depth");

  // a shift step never reads and writes the same ram entry
  a_ram_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("ram read and write collide");

  // emission stays inside the due run
  a_emit_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == swq_pkg::S_TK_EMIT) |-> (idx < k && k <= count))
    else $error("tick emission beyond due entries");

  // an insertion only happens with room left
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == swq_pkg::S_SET_INS) |-> (count < DEPTH_C && idx <= count))
    else $error("insert into full queue");

  // each woken item is loaded only with a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output register overwritten");

endmodule

// ===== tb/sv/sorted_alarm_wakeup_queue_tb.sv =====
// testbench for the sorted alarm wake-up queue: directed and random items
// checked against a shadow copy of the sorted queue; depends on swq_pkg
`timescale 1ns / 100ps

module sorted_alarm_wakeup_queue_tb;

  // queue geometry of the instance under test
  localparam int QDEPTH  = 16;
  localparam int IDW     = 8;
  // func value that the block ignores
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [swq_pkg::TIME_W-1:0] TIME_MAX = '1;

  // one item offered on the input channel
  typedef struct {
    logic [1:0]                 func;
    logic [IDW-1:0]             client_id;
    logic [swq_pkg::TIME_W-1:0] wake_time;
    logic [swq_pkg::TIME_W-1:0] now_time;
    bit                wait_drain;  // hold the item back until all results are in
  } alarm_req_t;

  // one result we expect on the output channel
  typedef struct {
    swq_pkg::status_t status;
    logic [IDW-1:0]   woken_id;
    logic             last;
  } alarm_resp_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 func = swq_pkg::FUNC_SET;
  logic [IDW-1:0]             client_id = '0;
  logic [swq_pkg::TIME_W-1:0] wake_time = '0;
  logic [swq_pkg::TIME_W-1:0] now_time = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [2:0]                 status;
  logic [IDW-1:0]             woken_id;
  logic                       last;

  alarm_req_t  req_pending[$];
  alarm_resp_t resp_expected[$];
  alarm_req_t  cur_req;

  // shadow copy of the alarm queue, sorted by wake time
  logic [swq_pkg::TIME_W-1:0] shadow_time[QDEPTH];
  logic [IDW-1:0]             shadow_id[QDEPTH];
  int                shadow_len = 0;

  int mismatches = 0;
  int sent_cnt   = 0;
  int rcvd_cnt   = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  sorted_alarm_wakeup_queue #(
    .DEPTH   (QDEPTH),
    .ID_BITS (IDW)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .client_id (client_id),
    .wake_time (wake_time),
    .now_time  (now_time),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .woken_id  (woken_id),
    .last      (last)
  );

  // 8 ns clock
  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_resp(input swq_pkg::status_t st, input logic [IDW-1:0] id,
                           input logic lst);
    alarm_resp_t r;
    r.status   = st;
    r.woken_id = id;
    r.last     = lst;
    resp_expected.push_back(r);
  endtask

  // apply one accepted item to the shadow queue and queue up its results
  task automatic compute_responses(input alarm_req_t rq);
    int pos;
    int k;
    int i;
    case (rq.func)
      swq_pkg::FUNC_SET: begin
        if (shadow_len >= QDEPTH) begin
          push_resp(swq_pkg::ST_FULL, rq.client_id, 1'b1);
        end else begin
          // a new alarm goes ahead of alarms with the same wake time
          pos = 0;
          while (pos < shadow_len && shadow_time[pos] < rq.wake_time) pos++;
          for (i = shadow_len; i > pos; i--) begin
            shadow_time[i] = shadow_time[i-1];
            shadow_id[i]   = shadow_id[i-1];
          end
          shadow_time[pos] = rq.wake_time;
          shadow_id[pos]   = rq.client_id;
          shadow_len++;
          push_resp(swq_pkg::ST_SET_OK, rq.client_id, 1'b1);
        end
      end
      swq_pkg::FUNC_REMOVE: begin
        // only the earliest alarm of that id goes
        pos = 0;
        while (pos < shadow_len && shadow_id[pos] != rq.client_id) pos++;
        if (pos >= shadow_len) begin
          push_resp(swq_pkg::ST_NOT_FOUND, rq.client_id, 1'b1);
        end else begin
          for (i = pos; i + 1 < shadow_len; i++) begin
            shadow_time[i] = shadow_time[i+1];
            shadow_id[i]   = shadow_id[i+1];
          end
          shadow_len--;
          push_resp(swq_pkg::ST_REMOVED, rq.client_id, 1'b1);
        end
      end
      swq_pkg::FUNC_TICK: begin
        k = 0;
        while (k < shadow_len && k < swq_pkg::MAX_RESULTS &&
               shadow_time[k] <= rq.now_time) k++;
        if (k == 0) begin
          push_resp(swq_pkg::ST_NONE_DUE, '0, 1'b1);
        end else begin
          for (i = 0; i < k; i++) push_resp(swq_pkg::ST_WOKEN, shadow_id[i], (i + 1 == k));
          for (i = 0; i + k < shadow_len; i++) begin
            shadow_time[i] = shadow_time[i+k];
            shadow_id[i]   = shadow_id[i+k];
          end
          shadow_len -= k;
        end
      end
      default: begin
        // unused func: no result, no change
      end
    endcase
  endtask

  function automatic logic [swq_pkg::TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[swq_pkg::TIME_W-1:0];
  endfunction

  task automatic add_req(input logic [1:0] f, input logic [IDW-1:0] id,
                         input logic [swq_pkg::TIME_W-1:0] wt,
                         input logic [swq_pkg::TIME_W-1:0] nt,
                         input bit drain);
    alarm_req_t rq;
    rq.func       = f;
    rq.client_id  = id;
    rq.wake_time  = wt;
    rq.now_time   = nt;
    rq.wait_drain = drain;
    req_pending.push_back(rq);
  endtask

  // driver: offers pending items, holds valid and payload until accepted
  always @(posedge clk) begin
    bit gap;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        compute_responses(cur_req);
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        // idle at random, except over one long stretch
        gap = (sent_cnt < 150 || sent_cnt >= 230) && ($urandom_range(99) < 18);
        if (req_pending.size() != 0 && !gap &&
            !(req_pending[0].wait_drain && resp_expected.size() != 0)) begin
          cur_req = req_pending.pop_front();
          in_valid  <= 1'b1;
          func      <= cur_req.func;
          client_id <= cur_req.client_id;
          wake_time <= cur_req.wake_time;
          now_time  <= cur_req.now_time;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result against the oldest expectation
  always @(posedge clk) begin
    alarm_resp_t r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        rcvd_cnt++;
        if (resp_expected.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: status %0d id %0d last %0d",
                                    status, woken_id, last));
        end else begin
          r = resp_expected.pop_front();
          if (status !== r.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, r.status));
          if (woken_id !== r.woken_id)
            report_mismatch($sformatf("woken_id %0d, expected %0d", woken_id, r.woken_id));
          if (last !== r.last)
            report_mismatch($sformatf("last %0d, expected %0d", last, r.last));
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && rcvd_cnt >= 60) begin
        hold_done = 1'b1;
        hold_left = 300;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (rcvd_cnt >= 150 && rcvd_cnt < 230) || ($urandom_range(99) >= 18);
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [swq_pkg::TIME_W-1:0] gen_now;
    logic [swq_pkg::TIME_W-1:0] t;
    logic [IDW-1:0]    id;
    int                n;
    int                mode;
    int                pick;
    int                i;

    // empty queue: tick with nothing due, remove of an absent id, ignored func
    add_req(swq_pkg::FUNC_TICK, 8'd0, '0, '0, 1'b0);
    add_req(swq_pkg::FUNC_REMOVE, 8'd5, '0, '0, 1'b0);
    add_req(FUNC_UNUSED, 8'd255, TIME_MAX, TIME_MAX, 1'b0);
    // extreme times and ids, equal wake times, a duplicate id
    add_req(swq_pkg::FUNC_SET, 8'd0, TIME_MAX, '0, 1'b0);
    add_req(swq_pkg::FUNC_SET, 8'd255, '0, TIME_MAX, 1'b0);
    add_req(swq_pkg::FUNC_SET, 8'd7, 63'd100, '0, 1'b0);
    add_req(swq_pkg::FUNC_SET, 8'd8, 63'd100, '0, 1'b0);
    add_req(swq_pkg::FUNC_SET, 8'd7, 63'd50, '0, 1'b0);
    // remove takes the earlier of the two alarms of id 7
    add_req(swq_pkg::FUNC_REMOVE, 8'd7, '0, '0, 1'b0);
    // fill to the brim, with more equal times among them
    for (i = 0; i < 12; i++)
      add_req(swq_pkg::FUNC_SET, 8'(20 + i), 63'((i * 37) % 150), '0, 1'b0);
    add_req(swq_pkg::FUNC_SET, 8'd200, 63'd1, '0, 1'b0);
    // everything due at once: a full run of woken items
    add_req(swq_pkg::FUNC_TICK, 8'd3, '0, TIME_MAX, 1'b0);

    // random part: phases that fill, drain or mix, times near a running clock
    gen_now = 63'd1000;
    n = 0;
    mode = 0;
    while (n < 375) begin
      if (n % 40 == 0) mode = $urandom_range(2);
      pick = $urandom_range(99);
      id = ($urandom_range(99) < 80) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      if ($urandom_range(99) < 4) begin
        // noise: ignored func, not counted
        add_req(FUNC_UNUSED, 8'($urandom_range(255)), rand_time(), rand_time(), 1'b0);
      end else begin
        if ((mode == 0 && pick < 75) || (mode == 1 && pick < 20) || (mode == 2 && pick < 45)) begin
          pick = $urandom_range(99);
          if (pick < 8)       t = rand_time();
          else if (pick < 10) t = TIME_MAX;
          else if (pick < 15) t = '0;
          else                t = gen_now + 63'($urandom_range(300));
          add_req(swq_pkg::FUNC_SET, id, t, rand_time(), (n == 0 || n == 200));
        end else if ((mode == 0 && pick < 85) || (mode == 1 && pick < 40) ||
                     (mode == 2 && pick < 65)) begin
          add_req(swq_pkg::FUNC_REMOVE, id, rand_time(), rand_time(), (n == 0 || n == 200));
        end else begin
          gen_now = gen_now + 63'($urandom_range(60));
          pick = $urandom_range(99);
          if (pick < 3)      t = rand_time();
          else if (pick < 5) t = TIME_MAX;
          else               t = gen_now;
          add_req(swq_pkg::FUNC_TICK, 8'($urandom_range(255)), rand_time(), t,
                  (n == 0 || n == 200));
        end
        n++;
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (req_pending.size() != 0 || in_valid || resp_expected.size() != 0)
      @(posedge clk);
    // room for a late or extra result after the last expected one
    repeat (100) @(posedge clk);
    if (mismatches == 0 && req_pending.size() == 0 && resp_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
src/swq_pkg.sv
src/swq_ram.sv
src/sorted_alarm_wakeup_queue.sv
tb/sv/sorted_alarm_wakeup_queue_tb.sv
